>>> rtl/kle_pkg.sv
// ---------------------------------------------------------------------------
// kle_pkg: shared types, codes and glyph tables of the keycode line editor
// Holds the HID key codes, event codes, controller/datapath handshake
// structs and the keycode-to-ASCII lookup functions.
// ---------------------------------------------------------------------------
package kle_pkg;

   // Field widths
   localparam int CHAR_W = 8;
   localparam int POS_W  = 7;
   localparam int EV_W   = 3;
   localparam int KEY_W  = 8;

   // Default line store depth
   localparam int KLE_LINE_DEPTH = 128;

   // Reset value of the max_length register
   localparam logic [POS_W-1:0] MAX_LEN_RESET = 7'd111;

   // HID usage codes
   localparam logic [KEY_W-1:0] KEY_BACKSPACE   = 8'd42;
   localparam logic [KEY_W-1:0] KEY_RIGHT       = 8'd79;
   localparam logic [KEY_W-1:0] KEY_LEFT        = 8'd80;
   localparam logic [KEY_W-1:0] KEY_ALNUM_FIRST = 8'd4;
   localparam logic [KEY_W-1:0] KEY_ALNUM_LAST  = 8'd39;
   localparam logic [KEY_W-1:0] KEY_PUNCT_FIRST = 8'd44;
   localparam logic [KEY_W-1:0] KEY_PUNCT_LAST  = 8'd56;
   localparam logic [KEY_W-1:0] KEY_PUNCT_SKIP  = 8'd50;

   // Modifier bytes that count as shift (left or right shift alone)
   localparam logic [7:0] MOD_LSHIFT = 8'd2;
   localparam logic [7:0] MOD_RSHIFT = 8'd32;

   // Event codes, also used as the internal operation code
   localparam logic [EV_W-1:0] EV_NONE   = 3'd0;
   localparam logic [EV_W-1:0] EV_INSERT = 3'd1;
   localparam logic [EV_W-1:0] EV_DELETE = 3'd2;
   localparam logic [EV_W-1:0] EV_RIGHT  = 3'd3;
   localparam logic [EV_W-1:0] EV_LEFT   = 3'd4;
   localparam logic [EV_W-1:0] EV_READ   = 3'd5;

   // Glyph tables
   localparam int ALNUM_COUNT = 36;
   localparam int PUNCT_COUNT = 13;
   localparam logic [8*ALNUM_COUNT-1:0] ALNUM_LOWER = "abcdefghijklmnopqrstuvwxyz1234567890";
   localparam logic [8*ALNUM_COUNT-1:0] ALNUM_UPPER = "ABCDEFGHIJKLMNOPQRSTUVWXYZ!@#$%^&*()";
   localparam logic [CHAR_W-1:0] PUNCT_PLAIN [PUNCT_COUNT] = '{
      8'h20, 8'h2D, 8'h3D, 8'h5B, 8'h5D, 8'h5C, 8'h00,
      8'h3B, 8'h27, 8'h60, 8'h2C, 8'h2E, 8'h2F
   };
   localparam logic [CHAR_W-1:0] PUNCT_SHIFT [PUNCT_COUNT] = '{
      8'h20, 8'h5F, 8'h2B, 8'h7B, 8'h7D, 8'h7C, 8'h00,
      8'h3A, 8'h22, 8'h7E, 8'h3C, 8'h3E, 8'h3F
   };

   // Controller to datapath commands
   typedef struct packed {
      logic accept;   // take the item on the request channel
      logic step;     // advance the tail shift by one character
      logic commit;   // update cursor/length, write inserted char
      logic load;     // load the response register
   } kle_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic busy;     // tail shift still moving characters
   } kle_status_type;

   // Letters and digits, idx = key - 4
   function automatic logic [CHAR_W-1:0] alnum_glyph(input logic [5:0] idx,
                                                     input logic       shift);
      int pos;
      pos = 8 * (ALNUM_COUNT - 1 - int'(idx));
      return shift ? ALNUM_UPPER[pos +: 8] : ALNUM_LOWER[pos +: 8];
   endfunction

   // Symbols, idx = key - 44
   function automatic logic [CHAR_W-1:0] punct_glyph(input logic [3:0] idx,
                                                     input logic       shift);
      return shift ? PUNCT_SHIFT[idx] : PUNCT_PLAIN[idx];
   endfunction

endpackage

>>> rtl/kle_ifs.sv
// ---------------------------------------------------------------------------
// kle_ifs: channel interfaces of the keycode line editor
// Request (key event / read), response and register write channels, each
// with valid/ready handshake and source/sink modports.
// ---------------------------------------------------------------------------
interface kle_req_if import kle_pkg::*;;
   logic             valid;
   logic             ready;
   logic             action;
   logic [7:0]       modifier_bits;
   logic [KEY_W-1:0] key_code;
   logic [POS_W-1:0] read_index;

   modport source (output valid, action, modifier_bits, key_code, read_index,
                   input ready);
   modport sink   (input valid, action, modifier_bits, key_code, read_index,
                   output ready);
endinterface

interface kle_rsp_if import kle_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_out;
   logic [POS_W-1:0]  cursor_pos;
   logic [POS_W-1:0]  line_length;
   logic [EV_W-1:0]   event_code;

   modport source (output valid, char_out, cursor_pos, line_length, event_code,
                   input ready);
   modport sink   (input valid, char_out, cursor_pos, line_length, event_code,
                   output ready);
endinterface

interface kle_csr_if import kle_pkg::*;;
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> rtl/kle_ctrl.sv
// ---------------------------------------------------------------------------
// kle_ctrl: sequencing controller of the keycode line editor
// Accepts one item, runs the tail shift, commits the edit and hands the
// result to the response register.
// ---------------------------------------------------------------------------
module kle_ctrl import kle_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           rsp_ready,
   output logic           rsp_valid,
   output kle_cmd_type    cmd,
   input  kle_status_type status
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SHIFT  = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Commands
   always_comb begin
      cmd.accept = (state_ff == ST_IDLE) && req_valid;
      cmd.step   = (state_ff == ST_SHIFT);
      cmd.commit = (state_ff == ST_COMMIT);
      cmd.load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SHIFT;
         ST_SHIFT:  if (!status.busy) state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_DONE;
         ST_DONE:   if (cmd.load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Response valid: set on load, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/kle_datapath.sv
// ---------------------------------------------------------------------------
// kle_datapath: line store, cursor and key decode of the keycode line editor
// Decodes key events, shifts the line tail one character per cycle through
// the line memory and holds the response payload.
// ---------------------------------------------------------------------------
module kle_datapath import kle_pkg::*; #(
   parameter int LINE_DEPTH = KLE_LINE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  kle_cmd_type       cmd,
   output kle_status_type    status,
   input  logic              req_action,
   input  logic [7:0]        req_modifier_bits,
   input  logic [KEY_W-1:0]  req_key_code,
   input  logic [POS_W-1:0]  req_read_index,
   input  logic              csr_write,
   input  logic [POS_W-1:0]  csr_data,
   output logic [CHAR_W-1:0] rsp_char_out,
   output logic [POS_W-1:0]  rsp_cursor_pos,
   output logic [POS_W-1:0]  rsp_line_length,
   output logic [EV_W-1:0]   rsp_event_code
);

   localparam int ADDR_W = $clog2(LINE_DEPTH);
   localparam int IDX_W  = (ADDR_W > POS_W) ? ADDR_W : POS_W;

   // Architectural state
   logic [POS_W-1:0]  cursor_ff, length_ff, max_len_ff;
   // Current item
   logic [EV_W-1:0]   op_ff;
   logic [CHAR_W-1:0] char_ff;
   logic              rhit_ff;
   // Tail shift
   logic [POS_W-1:0]  cnt_ff;
   logic              pend_ff;
   logic              del_ff;
   logic [ADDR_W-1:0] ptr_ff, wr_addr_ff;
   // Line memory
   logic [CHAR_W-1:0] line_mem [LINE_DEPTH];
   logic [CHAR_W-1:0] rdata_ff;
   // Response payload
   logic [CHAR_W-1:0] rsp_char_ff;
   logic [POS_W-1:0]  rsp_cursor_ff, rsp_length_ff;
   logic [EV_W-1:0]   rsp_event_ff;

   logic              shift_on, room, alnum_key, punct_key;
   logic [KEY_W-1:0]  alnum_off, punct_off;
   logic [EV_W-1:0]   op_in;
   logic [CHAR_W-1:0] glyph_in;
   logic [IDX_W-1:0]  cursor_x, length_m1_x, ridx_x;
   logic [POS_W-1:0]  span;
   logic              rd_en, wr_en;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [CHAR_W-1:0] wr_data;

   // Key decode against the current line state
   always_comb begin
      shift_on  = (req_modifier_bits == MOD_LSHIFT) || (req_modifier_bits == MOD_RSHIFT);
      room      = (length_ff < max_len_ff) && (int'(length_ff) < LINE_DEPTH);
      alnum_key = (req_key_code >= KEY_ALNUM_FIRST) && (req_key_code <= KEY_ALNUM_LAST);
      punct_key = (req_key_code >= KEY_PUNCT_FIRST) && (req_key_code <= KEY_PUNCT_LAST)
                  && (req_key_code != KEY_PUNCT_SKIP);
      alnum_off = req_key_code - KEY_ALNUM_FIRST;
      punct_off = req_key_code - KEY_PUNCT_FIRST;
      op_in     = EV_NONE;
      glyph_in  = '0;
      if (req_action) begin
         op_in = EV_READ;
      end else if (req_key_code == KEY_BACKSPACE) begin
         if (cursor_ff != '0) op_in = EV_DELETE;
      end else if (req_key_code == KEY_RIGHT) begin
         if (cursor_ff < length_ff) op_in = EV_RIGHT;
      end else if (req_key_code == KEY_LEFT) begin
         if (cursor_ff != '0) op_in = EV_LEFT;
      end else if (room && alnum_key) begin
         op_in    = EV_INSERT;
         glyph_in = alnum_glyph(alnum_off[5:0], shift_on);
      end else if (room && punct_key) begin
         op_in    = EV_INSERT;
         glyph_in = punct_glyph(punct_off[3:0], shift_on);
      end
   end

   // Address arithmetic in a width that covers both position and depth
   always_comb begin
      cursor_x    = IDX_W'(cursor_ff);
      length_m1_x = IDX_W'(length_ff) - IDX_W'(1);
      ridx_x      = IDX_W'(req_read_index);
      span        = length_ff - cursor_ff;
   end

   // Control registers: cursor, length, config, shift counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff  <= '0;
         length_ff  <= '0;
         max_len_ff <= MAX_LEN_RESET;
         op_ff      <= EV_NONE;
         cnt_ff     <= '0;
         pend_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            max_len_ff <= csr_data;
         end
         if (cmd.accept) begin
            op_ff   <= op_in;
            cnt_ff  <= (op_in == EV_DELETE || op_in == EV_INSERT) ? span : '0;
            pend_ff <= 1'b0;
         end else if (cmd.step) begin
            pend_ff <= (cnt_ff != '0);
            if (cnt_ff != '0) cnt_ff <= cnt_ff - POS_W'(1);
         end
         if (cmd.commit) begin
            case (op_ff)
               EV_DELETE: begin
                  cursor_ff <= cursor_ff - POS_W'(1);
                  length_ff <= length_ff - POS_W'(1);
               end
               EV_INSERT: begin
                  cursor_ff <= cursor_ff + POS_W'(1);
                  length_ff <= length_ff + POS_W'(1);
               end
               EV_RIGHT: cursor_ff <= cursor_ff + POS_W'(1);
               EV_LEFT:  cursor_ff <= cursor_ff - POS_W'(1);
               default:  ;
            endcase
         end
      end
   end

   // Item payload and shift pointers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         char_ff <= glyph_in;
         rhit_ff <= (req_read_index < length_ff);
         del_ff  <= (op_in == EV_DELETE);
         // delete walks up from the cursor, insert walks down from the end
         ptr_ff  <= (op_in == EV_DELETE) ? cursor_x[ADDR_W-1:0] : length_m1_x[ADDR_W-1:0];
      end else if (cmd.step && cnt_ff != '0) begin
         wr_addr_ff <= del_ff ? ptr_ff - ADDR_W'(1) : ptr_ff + ADDR_W'(1);
         ptr_ff     <= del_ff ? ptr_ff + ADDR_W'(1) : ptr_ff - ADDR_W'(1);
      end
   end

   // Memory port selection
   always_comb begin
      rd_en   = (cmd.accept && op_in == EV_READ) || (cmd.step && cnt_ff != '0);
      rd_addr = cmd.accept ? ridx_x[ADDR_W-1:0] : ptr_ff;
      wr_en   = pend_ff || (cmd.commit && op_ff == EV_INSERT);
      wr_addr = pend_ff ? wr_addr_ff : cursor_x[ADDR_W-1:0];
      wr_data = pend_ff ? rdata_ff : char_ff;
   end

   // Line memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= line_mem[rd_addr];
      end
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_char_ff   <= (op_ff == EV_READ) ? (rhit_ff ? rdata_ff : '0) : char_ff;
         rsp_cursor_ff <= cursor_ff;
         rsp_length_ff <= length_ff;
         rsp_event_ff  <= op_ff;
      end
   end

   assign status.busy     = (cnt_ff != '0) || pend_ff;
   assign rsp_char_out    = rsp_char_ff;
   assign rsp_cursor_pos  = rsp_cursor_ff;
   assign rsp_line_length = rsp_length_ff;
   assign rsp_event_code  = rsp_event_ff;

endmodule

>>> rtl/keycode_line_editor.sv
// ---------------------------------------------------------------------------
// keycode_line_editor: HID key event driven line editor
// Channel  | dir | payload
// req_if   | in  | action, modifier_bits, key_code, read_index
// rsp_if   | out | char_out, cursor_pos, line_length, event_code
// csr_if   | in  | data (max_length)
//
// Each item runs through idle (accept), shift, commit and done (load response).
// Insert/delete move the n = length - cursor tail characters one character per
// cycle through the line memory in shift; the next item is taken after the load.
// Reset is synchronous: cursor and length to 0, max_length to 111; the line
// memory is not cleared, entries past the length are never returned (read as 0).
// A held response stalls the next item in its last step; input then stalls.
// ---------------------------------------------------------------------------
module keycode_line_editor import kle_pkg::*; #(
   parameter int LINE_DEPTH = KLE_LINE_DEPTH
) (
   input logic       clock,
   input logic       reset,
   kle_req_if.sink   req_if,
   kle_rsp_if.source rsp_if,
   kle_csr_if.sink   csr_if
);

   kle_cmd_type    cmd;
   kle_status_type status;
   logic           req_ready;
   logic           rsp_valid;

   // Register port never stalls
   assign csr_if.ready = 1'b1;
   assign req_if.ready = req_ready;
   assign rsp_if.valid = rsp_valid;

   kle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   kle_datapath #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_action        (req_if.action),
      .req_modifier_bits (req_if.modifier_bits),
      .req_key_code      (req_if.key_code),
      .req_read_index    (req_if.read_index),
      .csr_write         (csr_if.valid),
      .csr_data          (csr_if.data),
      .rsp_char_out      (rsp_if.char_out),
      .rsp_cursor_pos    (rsp_if.cursor_pos),
      .rsp_line_length   (rsp_if.line_length),
      .rsp_event_code    (rsp_if.event_code)
   );

   // Busy right after an item is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request accepted while an item is in work");

   // Cursor stays inside the line
   a_cursor_in_line: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.cursor_pos <= rsp_if.line_length))
      else $error("cursor beyond line length");

   // An insert always reports a printable character
   a_insert_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.event_code == EV_INSERT) |-> (rsp_if.char_out != '0))
      else $error("insert reported without a character");

   // Ignored keys report no character
   a_none_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.event_code == EV_NONE) |-> (rsp_if.char_out == '0))
      else $error("ignored key reported a character");

endmodule
